@@ hw/rtl/fpt_pkg.sv @@
// fee percentile tracker: shared types, operation and register codes, constants
// no dependencies

package fpt_pkg;

	localparam logic [2:0] OP_RECORD   = 3'd0;
	localparam logic [2:0] OP_BLOCK    = 3'd1;
	localparam logic [2:0] OP_CLASSIFY = 3'd2;
	localparam logic [2:0] OP_ESTIMATE = 3'd3;
	localparam logic [2:0] OP_STATS    = 3'd4;

	localparam logic [1:0] CFG_ADAPTIVE = 2'd0;
	localparam logic [1:0] CFG_TARGET   = 2'd1;
	localparam logic [1:0] CFG_GAIN     = 2'd2;
	localparam logic [1:0] CFG_LIMIT    = 2'd3;

	localparam logic [2:0] SLOT_MIN  = 3'd0;
	localparam logic [2:0] SLOT_MAX  = 3'd1;
	localparam logic [2:0] SLOT_P50  = 3'd2;
	localparam logic [2:0] SLOT_P90  = 3'd3;
	localparam logic [2:0] SLOT_P99  = 3'd4;
	localparam logic [2:0] SLOT_P25  = 3'd5;
	localparam int         SLOT_NUM  = 6;

	localparam logic [1:0] TIER_LOW    = 2'd0;
	localparam logic [1:0] TIER_NORMAL = 2'd1;
	localparam logic [1:0] TIER_HIGH   = 2'd2;
	localparam logic [1:0] TIER_URGENT = 2'd3;

	localparam logic [63:0] MIN_BASE   = 64'd1000;
	localparam logic [16:0] LOAD_ONE   = 17'd65536;
	localparam int          RECIP_SHIFT = 26;

	localparam logic signed [35:0] MULT_ONE  = 36'sd268435456;
	localparam logic signed [35:0] MULT_LOW  = 36'sd234881024;
	localparam logic signed [35:0] MULT_HIGH = 36'sd301989888;

	// k * ceil(2^26 / 100), exact for k * (n - 1) below 2^20
	function automatic logic [26:0] rank_recip(input logic [2:0] slot);
		logic [26:0] r;
		begin
			case (slot)
				SLOT_P50: r = 27'd33554450;
				SLOT_P90: r = 27'd60398010;
				SLOT_P99: r = 27'd66437811;
				SLOT_P25: r = 27'd16777225;
				default:  r = 27'd0;
			endcase
			return r;
		end
	endfunction

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE
	} cell_op_t;

	typedef struct packed {
		cell_op_t    op;
		logic [63:0] key;
	} cell_cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TRIM_CHK,
		ST_TRIM_EX,
		ST_INSERT,
		ST_BASE_GO,
		ST_BASE_WAIT,
		ST_RANK_IX,
		ST_RANK_RD,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [63:0] fee_amount;
		logic        was_included;
		logic [16:0] block_load;
		logic [1:0]  wanted_tier;
	} item_t;

	typedef struct packed {
		logic [1:0]  fee_tier;
		logic [63:0] estimated_fee;
		logic [63:0] lowest_fee;
		logic [63:0] highest_fee;
		logic [63:0] p50_value;
		logic [63:0] p90_value;
		logic [63:0] p99_value;
		logic [8:0]  window_count;
		logic [8:0]  incl_count;
		logic [63:0] base_level;
	} result_t;

endpackage

@@ hw/rtl/fpt_cell.sv @@
// fee percentile tracker: one cell of the sorted fee row
// depends on fpt_pkg

module fpt_cell (
	input  logic              clk,
	input  fpt_pkg::cell_cmd_t cmd,
	input  logic              below,
	input  logic              at_end,
	input  logic [63:0]       left_val,
	input  logic              left_gt,
	input  logic [63:0]       right_val,
	output logic [63:0]       val,
	output logic              gt
);
	import fpt_pkg::*;

	logic [63:0] val_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_INSERT: begin
				if ((below && (val_q > cmd.key)) || at_end) begin
					val_q <= left_gt ? left_val : cmd.key;
				end
			end
			CELL_REMOVE: begin
				if (below && (val_q >= cmd.key)) begin
					val_q <= right_val;
				end
			end
			default: begin
			end
		endcase
	end

	assign val = val_q;
	assign gt  = val_q > cmd.key;

endmodule

@@ hw/rtl/fpt_base_upd.sv @@
// fee percentile tracker: three stage base fee update (multiplier, clamp, scale)
// depends on fpt_pkg

module fpt_base_upd (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [16:0] load,
	input  logic [16:0] target,
	input  logic [15:0] gain,
	input  logic [63:0] base,
	output logic        done,
	output logic [63:0] base_next
);
	import fpt_pkg::*;

	logic               v_s1, v_s2, v_s3;
	logic signed [34:0] dm_s1;
	logic [60:0]        hi_s2, lo_s2;
	logic [63:0]        nb_s3;
	logic [16:0]        l_w, t_w;
	logic signed [17:0] diff_w;
	logic signed [16:0] gain_w;
	logic signed [35:0] m_full;
	logic [28:0]        mu_w;
	logic [64:0]        sum_w;
	logic [63:0]        nb_w;

	always_comb begin
		l_w    = (load > LOAD_ONE) ? LOAD_ONE : load;
		t_w    = (target > LOAD_ONE) ? LOAD_ONE : target;
		diff_w = $signed({1'b0, l_w}) - $signed({1'b0, t_w});
		gain_w = $signed({1'b0, gain});
		m_full = MULT_ONE + {dm_s1[34], dm_s1};
		if (m_full < MULT_LOW) begin
			mu_w = MULT_LOW[28:0];
		end else if (m_full > MULT_HIGH) begin
			mu_w = MULT_HIGH[28:0];
		end else begin
			mu_w = m_full[28:0];
		end
		sum_w = {1'b0, hi_s2[59:0], 4'b0} + {32'b0, lo_s2[60:28]};
		if (hi_s2[60] || sum_w[64]) begin
			nb_w = '1;
		end else begin
			nb_w = sum_w[63:0];
		end
		if (nb_w < MIN_BASE) begin
			nb_w = MIN_BASE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		dm_s1 <= diff_w * gain_w;
		hi_s2 <= 61'(base[63:32]) * 61'(mu_w);
		lo_s2 <= 61'(base[31:0]) * 61'(mu_w);
		nb_s3 <= nb_w;
	end

	assign done      = v_s3;
	assign base_next = nb_s3;

endmodule

@@ hw/rtl/fee_percentile_tracker_unit.sv @@
// Fee percentile tracker top level: control sequencer, sorted cell row, arrival ring.
// Depends on fpt_pkg, fpt_cell and fpt_base_upd.
//
// Takes one item at a time. A record drops the oldest fee of a full window before
// it is inserted, and a block update runs the base fee update unless adaptive
// updates are off; the next item can be taken once result_valid has risen. Every
// item ends in the six rank reads (min, max, p50, p90, p99, p25) that go one after
// another through the single read port of the sorted cell row. A write to
// history_limit drops the oldest fees one at a time, during which neither port
// takes a transfer. A finished result waits in the output register while the next
// item is taken.

module fee_percentile_tracker_unit #(
	parameter int HISTORY_DEPTH  = 256,
	parameter int RESET_BASE_FEE = 5000
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  fpt_pkg::item_t  item,
	output logic            result_valid,
	input  logic            result_stall,
	output fpt_pkg::result_t result,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [1:0]      cfg_index,
	input  logic [16:0]     cfg_data
);
	import fpt_pkg::*;

	localparam int AW = $clog2(HISTORY_DEPTH);
	localparam int CW = $clog2(HISTORY_DEPTH + 1);

	state_t       state_q, state_d;
	item_t        item_q;
	logic [CW-1:0] count_q, incl_q;
	logic [AW-1:0] oldest_q;
	logic [63:0]  base_q;
	logic         aen_q;
	logic [16:0]  tgt_q;
	logic [15:0]  gain_q;
	logic [8:0]   hlim_q;
	logic         cfg_trim_q;
	logic [2:0]   slot_q;
	logic [AW-1:0] ridx_q;
	logic [63:0]  rank_q [SLOT_NUM];
	logic         result_valid_q;
	result_t      result_q;

	logic [64:0]  ring_mem [HISTORY_DEPTH];
	logic [64:0]  ring_rd_q;

	logic [63:0]  cell_val [HISTORY_DEPTH];
	logic         cell_gt  [HISTORY_DEPTH];
	logic         below_w  [HISTORY_DEPTH];
	logic         at_end_w [HISTORY_DEPTH];

	cell_cmd_t    cell_cmd;
	logic         item_xfer, cfg_xfer, base_start, base_done, ring_we, need_drop;
	logic [63:0]  base_next;
	logic [CW-1:0] lim_w, cnt_m1;
	logic [AW:0]  slot_sum;
	logic [AW-1:0] wr_slot, oldest_nx, ridx_w;
	logic [CW+26:0] rprod;
	logic [65:0]  b3_w, b5_w;
	logic [63:0]  b2_s, b3_s, b5_s;
	logic [63:0]  t1_w, t2_w, t3_w;
	logic         empty_w;
	result_t      res_w;

	assign item_xfer = item_valid && !item_stall;
	assign cfg_xfer  = cfg_valid && cfg_ready;

	// effective limit, drop test, ring write slot and rank index
	always_comb begin
		if (32'(hlim_q) < 32'd100) begin
			lim_w = CW'(100);
		end else if (32'(hlim_q) > 32'(HISTORY_DEPTH)) begin
			lim_w = CW'(HISTORY_DEPTH);
		end else begin
			lim_w = CW'(hlim_q);
		end
		need_drop = cfg_trim_q ? (count_q > lim_w) : (count_q >= lim_w);
		slot_sum  = (AW+1)'(oldest_q) + (AW+1)'(count_q);
		if (slot_sum >= (AW+1)'(HISTORY_DEPTH)) begin
			wr_slot = AW'(slot_sum - (AW+1)'(HISTORY_DEPTH));
		end else begin
			wr_slot = AW'(slot_sum);
		end
		oldest_nx = (oldest_q == AW'(HISTORY_DEPTH - 1)) ? '0 : oldest_q + 1'b1;
		cnt_m1 = count_q - 1'b1;
		rprod  = (CW+27)'(cnt_m1) * (CW+27)'(rank_recip(slot_q));
		case (slot_q)
			SLOT_MIN: ridx_w = '0;
			SLOT_MAX: ridx_w = AW'(cnt_m1);
			default:  ridx_w = AW'(rprod >> RECIP_SHIFT);
		endcase
	end

	// next state and control
	always_comb begin
		state_d    = state_q;
		item_stall = 1'b1;
		cfg_ready  = 1'b0;
		cell_cmd   = '{op: CELL_HOLD, key: item_q.fee_amount};
		base_start = 1'b0;
		ring_we    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				cfg_ready  = !item_valid;
				if (item_valid) begin
					case (item.operation)
						OP_RECORD: state_d = ST_TRIM_CHK;
						OP_BLOCK:  state_d = aen_q ? ST_BASE_GO : ST_RANK_IX;
						default:   state_d = ST_RANK_IX;
					endcase
				end else if (cfg_valid && (cfg_index == CFG_LIMIT)) begin
					state_d = ST_TRIM_CHK;
				end
			end
			ST_TRIM_CHK: begin
				if (need_drop) begin
					state_d = ST_TRIM_EX;
				end else begin
					state_d = cfg_trim_q ? ST_IDLE : ST_INSERT;
				end
			end
			ST_TRIM_EX: begin
				cell_cmd = '{op: CELL_REMOVE, key: ring_rd_q[63:0]};
				state_d  = ST_TRIM_CHK;
			end
			ST_INSERT: begin
				cell_cmd = '{op: CELL_INSERT, key: item_q.fee_amount};
				ring_we  = 1'b1;
				state_d  = ST_RANK_IX;
			end
			ST_BASE_GO: begin
				base_start = 1'b1;
				state_d    = ST_BASE_WAIT;
			end
			ST_BASE_WAIT: begin
				if (base_done) begin
					state_d = ST_RANK_IX;
				end
			end
			ST_RANK_IX: begin
				state_d = ST_RANK_RD;
			end
			ST_RANK_RD: begin
				state_d = (slot_q == SLOT_P25) ? ST_FINISH : ST_RANK_IX;
			end
			ST_FINISH: begin
				if (!result_valid_q || !result_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// result assembly
	always_comb begin
		empty_w = (count_q == '0);
		b3_w = {2'b0, base_q} + {1'b0, base_q, 1'b0};
		b5_w = {2'b0, base_q} + {base_q, 2'b0};
		b2_s = base_q[63] ? '1 : {base_q[62:0], 1'b0};
		b3_s = (b3_w[65:64] != 2'b0) ? '1 : b3_w[63:0];
		b5_s = (b5_w[65:64] != 2'b0) ? '1 : b5_w[63:0];
		t1_w = empty_w ? base_q : rank_q[SLOT_P25];
		t2_w = empty_w ? b3_s : rank_q[SLOT_P90];
		t3_w = empty_w ? b5_s : rank_q[SLOT_P99];
		res_w = '0;
		res_w.window_count = 9'(count_q);
		res_w.incl_count   = 9'(incl_q);
		res_w.base_level   = base_q;
		if (!empty_w) begin
			res_w.lowest_fee  = rank_q[SLOT_MIN];
			res_w.highest_fee = rank_q[SLOT_MAX];
			res_w.p50_value   = rank_q[SLOT_P50];
			res_w.p90_value   = rank_q[SLOT_P90];
			res_w.p99_value   = rank_q[SLOT_P99];
		end
		case (item_q.operation)
			OP_CLASSIFY: begin
				if (item_q.fee_amount >= t3_w) begin
					res_w.fee_tier = TIER_URGENT;
				end else if (item_q.fee_amount >= t2_w) begin
					res_w.fee_tier = TIER_HIGH;
				end else if (item_q.fee_amount >= t1_w) begin
					res_w.fee_tier = TIER_NORMAL;
				end else begin
					res_w.fee_tier = TIER_LOW;
				end
			end
			OP_ESTIMATE: begin
				case (item_q.wanted_tier)
					TIER_LOW:    res_w.estimated_fee = empty_w ? base_q : rank_q[SLOT_P25];
					TIER_NORMAL: res_w.estimated_fee = empty_w ? b2_s : rank_q[SLOT_P50];
					TIER_HIGH:   res_w.estimated_fee = empty_w ? b3_s : rank_q[SLOT_P90];
					default:     res_w.estimated_fee = empty_w ? b5_s : rank_q[SLOT_P99];
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			count_q        <= '0;
			incl_q         <= '0;
			oldest_q       <= '0;
			base_q         <= 64'(RESET_BASE_FEE);
			aen_q          <= 1'b1;
			tgt_q          <= 17'd32768;
			gain_q         <= 16'd4096;
			hlim_q         <= 9'd256;
			cfg_trim_q     <= 1'b0;
			slot_q         <= SLOT_MIN;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == ST_FINISH) && (!result_valid_q || !result_stall)) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					slot_q <= SLOT_MIN;
					if (item_xfer) begin
						cfg_trim_q <= 1'b0;
					end else if (cfg_xfer) begin
						cfg_trim_q <= 1'b1;
						case (cfg_index)
							CFG_ADAPTIVE: aen_q  <= cfg_data[0];
							CFG_TARGET:   tgt_q  <= cfg_data;
							CFG_GAIN:     gain_q <= cfg_data[15:0];
							CFG_LIMIT:    hlim_q <= cfg_data[8:0];
							default: begin
							end
						endcase
					end
				end
				ST_TRIM_EX: begin
					count_q  <= count_q - 1'b1;
					oldest_q <= oldest_nx;
					if (ring_rd_q[64] && (incl_q != '0)) begin
						incl_q <= incl_q - 1'b1;
					end
				end
				ST_INSERT: begin
					count_q <= count_q + 1'b1;
					if (item_q.was_included) begin
						incl_q <= incl_q + 1'b1;
					end
				end
				ST_BASE_WAIT: begin
					if (base_done) begin
						base_q <= base_next;
					end
				end
				ST_RANK_RD: begin
					slot_q <= slot_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_xfer) begin
			item_q <= item;
		end
		if (state_q == ST_RANK_IX) begin
			ridx_q <= ridx_w;
		end
		if (state_q == ST_RANK_RD) begin
			rank_q[slot_q] <= cell_val[ridx_q];
		end
		if ((state_q == ST_FINISH) && (!result_valid_q || !result_stall)) begin
			result_q <= res_w;
		end
	end

	// arrival ring
	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[wr_slot] <= {item_q.was_included, item_q.fee_amount};
		end
		ring_rd_q <= ring_mem[oldest_q];
	end

	// sorted cell row
	for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
		assign below_w[i]  = CW'(i) < count_q;
		assign at_end_w[i] = CW'(i) == count_q;
		fpt_cell u_cell (
			.clk       (clk),
			.cmd       (cell_cmd),
			.below     (below_w[i]),
			.at_end    (at_end_w[i]),
			.left_val  ((i == 0) ? cell_val[0] : cell_val[(i == 0) ? 0 : i - 1]),
			.left_gt   ((i == 0) ? 1'b0 : cell_gt[(i == 0) ? 0 : i - 1]),
			.right_val (cell_val[(i == HISTORY_DEPTH - 1) ? i : i + 1]),
			.val       (cell_val[i]),
			.gt        (cell_gt[i])
		);
	end

	fpt_base_upd u_base (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (base_start),
		.load      (item_q.block_load),
		.target    (tgt_q),
		.gain      (gain_q),
		.base      (base_q),
		.done      (base_done),
		.base_next (base_next)
	);

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

@@ hw/rtl/fpt_checker.sv @@
// fee percentile tracker: port level checks over time, bound to the top level
// depends on fpt_pkg and fee_percentile_tracker_unit

module fpt_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             result_valid,
	input logic             result_stall,
	input fpt_pkg::result_t result
);
	import fpt_pkg::*;

	// stalled result transfer holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	a_base_floor: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.base_level >= MIN_BASE)
		else $error("base fee below floor");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.window_count != 9'd0) |->
		(result.lowest_fee <= result.p50_value) &&
		(result.p50_value <= result.p90_value) &&
		(result.p99_value <= result.highest_fee))
		else $error("window ranks out of order");

	a_tier_est: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.fee_tier != TIER_LOW) |-> result.estimated_fee == 64'd0)
		else $error("tier and estimate both set");

endmodule

bind fee_percentile_tracker_unit fpt_checker u_fpt_checker (.*);
